@@ src/assert_macros.svh @@
// Assertion helpers for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_RST(label, clk, prop, msg)
`endif
`endif

@@ src/dgs_pkg.sv @@
// ----------------------------------------------------------------------------
// dgs_pkg
// Types and codes shared by the directed graph store.
// ----------------------------------------------------------------------------
package dgs_pkg;
   localparam int MaxNodesDefault   = 16;
   localparam int ValueWidthDefault = 32;

   localparam logic [2:0] MODE_INS_NODE = 3'd0;
   localparam logic [2:0] MODE_ERA_NODE = 3'd1;
   localparam logic [2:0] MODE_INS_EDGE = 3'd2;
   localparam logic [2:0] MODE_ERA_EDGE = 3'd3;
   localparam logic [2:0] MODE_QUERY    = 3'd4;
   localparam logic [2:0] MODE_READ     = 3'd5;
   localparam logic [2:0] MODE_CLEAR    = 3'd6;
   localparam logic [2:0] MODE_NOP      = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
      logic [3:0]         slot_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        adjacency_mask;
      logic signed [31:0] value_out;
      logic [4:0]         node_count;
   } rsp_word_type;
endpackage

@@ src/directed_graph_store_unit.sv @@
// ----------------------------------------------------------------------------
// directed_graph_store_unit
// Directed graph of unique node values with per-node adjacency rows.
// ----------------------------------------------------------------------------
// Usage: a request word (req_valid/req_stall) carries mode, two node values
// and an index; one response word (rsp_valid/rsp_stall) comes back per
// request. Requests are handled one at a time by a sequencer that walks the
// node table one entry per cycle through a single comparator.
// Node insert and query take one lookup, edge modes take two lookups, and an
// erase takes a lookup, then row compaction through the shared column drop
// unit. Read, clear and no-op skip the lookup. req_stall stays high while a
// response word is held, so the next request is accepted at the earliest in
// the cycle after the response word has been taken.
// Reset empties the graph: count and all rows zero; values need no reset.
// A stalled response holds its word unchanged until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module directed_graph_store_unit #(
   parameter int MAX_NODES   = dgs_pkg::MaxNodesDefault,
   parameter int VALUE_WIDTH = dgs_pkg::ValueWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dgs_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dgs_pkg::rsp_word_type rsp_word
);
   import dgs_pkg::*;

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIND  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [VALUE_WIDTH-1:0] vals_ff [MAX_NODES];
   logic [MAX_NODES-1:0]   rows_ff [MAX_NODES];
   logic [CW-1:0]          count_ff;
   logic [2:0]             state_ff;
   req_word_type           req_ff;
   logic                   which_ff;   // 0 first value, 1 second
   logic [CW-1:0]          scan_ff;
   logic                   fa_ff, fb_ff;
   logic [IW-1:0]          ia_ff, ib_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_ff;
   rsp_word_type           rsp_in;

   logic [VALUE_WIDTH-1:0] key_a, key_b, key, cur_val;
   logic [MAX_NODES-1:0]   cur_row, drop_row;
   logic [IW-1:0]          scan_idx, shift_src, row_sel;
   logic                   hit;

   function automatic logic [VALUE_WIDTH-1:0] ext(input logic [31:0] v);
      logic [63:0] w;
      w = {{32{v[31]}}, v};
      return w[VALUE_WIDTH-1:0];
   endfunction

   assign key_a     = ext(req_ff.first_value);
   assign key_b     = ext(req_ff.second_value);
   assign key       = which_ff ? key_b : key_a;
   assign scan_idx  = scan_ff[IW-1:0];
   assign shift_src = scan_idx + 1'b1;
   // at and above the gap a row is refilled from the one above it
   assign row_sel   = (state_ff == S_SHIFT && scan_idx >= ia_ff) ? shift_src : scan_idx;
   assign cur_val   = vals_ff[scan_idx];
   assign cur_row   = rows_ff[row_sel];
   assign hit       = (cur_val == key);

   // shared column drop unit: remove bit ia_ff and close the gap
   always_comb begin
      drop_row = '0;
      for (int j = 0; j < MAX_NODES; j++) begin
         if (j < ia_ff)
            drop_row[j] = cur_row[j];
         else if (j + 1 < MAX_NODES)
            drop_row[j] = cur_row[j + 1];
      end
   end

   // response word for the operation held in req_ff
   always_comb begin
      rsp_in            = '0;
      rsp_in.status     = ST_OK;
      rsp_in.node_count = 5'(count_ff);
      case (req_ff.mode) inside
         MODE_INS_NODE: begin
            if (fa_ff) rsp_in.status = ST_REFUSED;
            else if (count_ff >= CW'(MAX_NODES)) rsp_in.status = ST_FULL;
            else rsp_in.node_count = 5'(count_ff + 1'b1);
         end
         MODE_ERA_NODE: begin
            if (!fa_ff) rsp_in.status = ST_REFUSED;
         end
         MODE_INS_EDGE, MODE_ERA_EDGE: begin
            if (!fa_ff || !fb_ff) rsp_in.status = ST_REFUSED;
            else if (req_ff.mode == MODE_INS_EDGE && rows_ff[ia_ff][ib_ff])
               rsp_in.status = ST_REFUSED;
         end
         MODE_QUERY: begin
            if (!fa_ff) rsp_in.status = ST_REFUSED;
            else rsp_in.adjacency_mask = 16'(rows_ff[ia_ff]);
         end
         MODE_READ: begin
            if ({1'b0, req_ff.slot_index} >= 5'(count_ff)
                || 32'(req_ff.slot_index) >= 32'(MAX_NODES))
               rsp_in.status = ST_RANGE;
            else
               rsp_in.value_out = 32'(signed'(vals_ff[req_ff.slot_index[IW-1:0]]));
         end
         MODE_CLEAR: rsp_in.node_count = '0;
         default: ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_NODES; r++) rows_ff[r] <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff   <= req_word;
                  scan_ff  <= '0;
                  which_ff <= 1'b0;
                  fa_ff    <= 1'b0;
                  fb_ff    <= 1'b0;
                  ia_ff    <= '0;
                  ib_ff    <= '0;
                  if (req_word.mode == MODE_READ || req_word.mode == MODE_CLEAR
                      || req_word.mode == MODE_NOP)
                     state_ff <= S_EXEC;
                  else
                     state_ff <= S_FIND;
               end
            end
            S_FIND: begin
               if (scan_ff >= count_ff) begin
                  scan_ff <= '0;
                  if (!which_ff && (req_ff.mode == MODE_INS_EDGE ||
                                    req_ff.mode == MODE_ERA_EDGE))
                     which_ff <= 1'b1;
                  else
                     state_ff <= S_EXEC;
               end else if (hit) begin
                  scan_ff <= '0;
                  if (!which_ff) begin
                     fa_ff <= 1'b1;
                     ia_ff <= scan_idx;
                  end else begin
                     fb_ff <= 1'b1;
                     ib_ff <= scan_idx;
                  end
                  if (!which_ff && (req_ff.mode == MODE_INS_EDGE ||
                                    req_ff.mode == MODE_ERA_EDGE))
                     which_ff <= 1'b1;
                  else
                     state_ff <= S_EXEC;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_EXEC: begin
               rsp_ff <= rsp_in;
               if (req_ff.mode == MODE_ERA_NODE && fa_ff) begin
                  scan_ff  <= '0;
                  state_ff <= S_SHIFT;
               end else
                  state_ff <= S_DONE;
               case (req_ff.mode) inside
                  MODE_INS_NODE: begin
                     if (!fa_ff && count_ff < CW'(MAX_NODES)) begin
                        vals_ff[count_ff[IW-1:0]] <= key_a;
                        rows_ff[count_ff[IW-1:0]] <= '0;
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  MODE_INS_EDGE, MODE_ERA_EDGE: begin
                     if (fa_ff && fb_ff) begin
                        if (req_ff.mode == MODE_INS_EDGE) begin
                           if (!rows_ff[ia_ff][ib_ff]) rows_ff[ia_ff][ib_ff] <= 1'b1;
                        end else
                           rows_ff[ia_ff][ib_ff] <= 1'b0;
                     end
                  end
                  MODE_CLEAR: begin
                     count_ff <= '0;
                     for (int r = 0; r < MAX_NODES; r++) rows_ff[r] <= '0;
                  end
                  default: ;
               endcase
            end
            S_SHIFT: begin
               // row scan_idx takes its own (below gap) or next row, column dropped; top rows zeroed
               if (scan_ff >= CW'(MAX_NODES)) begin
                  count_ff          <= count_ff - 1'b1;
                  rsp_ff.node_count <= 5'(count_ff - 1'b1);
                  state_ff          <= S_DONE;
               end else begin
                  if (scan_idx < ia_ff) begin
                     rows_ff[scan_idx] <= drop_row;
                  end else if (scan_ff + 1'b1 < count_ff) begin
                     rows_ff[scan_idx] <= drop_row;
                     vals_ff[scan_idx] <= vals_ff[shift_src];
                  end else
                     rows_ff[scan_idx] <= '0;
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_count_range, clock, reset, count_ff <= CW'(MAX_NODES), "count overflow")
   `ASSERT_CLK(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> req_stall, "accept while busy")
   `ASSERT_CLK(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE, "stray response")
endmodule
